// File: sv/imo_pkg.sv
// Shared types and constants for the IMU offset-removal moving-average filter.
// No dependencies; every other file in sv/ imports this package.
package imo_pkg;

  localparam int DATA_W     = 16;
  localparam int NUM_AXES   = 6;
  // Averaging window length in samples; must be a power of two (2..64).
  localparam int WINDOW_LEN = 8;
  localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W      = DATA_W + POS_W;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]  wsum_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef sample_t [NUM_AXES-1:0]   axes_t;

  // Bias register indexes; register i corrects axis i.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_BIAS_X = 3'd0,
    REG_ACCEL_BIAS_Y = 3'd1,
    REG_ACCEL_BIAS_Z = 3'd2,
    REG_GYRO_BIAS_X  = 3'd3,
    REG_GYRO_BIAS_Y  = 3'd4,
    REG_GYRO_BIAS_Z  = 3'd5
  } cfg_reg_t;

  // Axis slots in axes_t, same order as the registers.
  localparam int AX_ACCEL_X = 0;
  localparam int AX_ACCEL_Y = 1;
  localparam int AX_ACCEL_Z = 2;
  localparam int AX_GYRO_X  = 3;
  localparam int AX_GYRO_Y  = 4;
  localparam int AX_GYRO_Z  = 5;

  // Control from the top level to each axis lane.
  typedef struct packed {
    logic upd;   // commit one corrected sample into the window
    pos_t pos;   // ring slot to overwrite
  } lane_ctrl_t;

endpackage

// File: sv/imo_if.sv
// Valid/ready stream interfaces for the raw sample and filtered result beats.
// Depends on imo_pkg.
interface imo_in_if;
  import imo_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_in_x;
  sample_t accel_in_y;
  sample_t accel_in_z;
  sample_t gyro_in_x;
  sample_t gyro_in_y;
  sample_t gyro_in_z;

  modport source (output valid, output accel_in_x, output accel_in_y, output accel_in_z,
                  output gyro_in_x, output gyro_in_y, output gyro_in_z, input ready);
  modport sink   (input valid, input accel_in_x, input accel_in_y, input accel_in_z,
                  input gyro_in_x, input gyro_in_y, input gyro_in_z, output ready);
endinterface

interface imo_out_if;
  import imo_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_out_x;
  sample_t accel_out_y;
  sample_t accel_out_z;
  sample_t gyro_out_x;
  sample_t gyro_out_y;
  sample_t gyro_out_z;

  modport source (output valid, output accel_out_x, output accel_out_y, output accel_out_z,
                  output gyro_out_x, output gyro_out_y, output gyro_out_z, input ready);
  modport sink   (input valid, input accel_out_x, input accel_out_y, input accel_out_z,
                  input gyro_out_x, input gyro_out_y, input gyro_out_z, output ready);
endinterface

// File: sv/imu_offset_moving_average_top.sv
// IMU offset removal and moving-average filter, top level.
// Stream ports and pipeline; depends on imo_pkg, imo_if, imo_bias, imo_lane.
//
// Each input beat carries one six-axis IMU sample (accel x/y/z, gyro x/y/z,
// signed 16 bit). Per axis the programmed bias is subtracted with 16-bit
// wraparound, the result replaces the oldest entry in that axis's window of
// the last WINDOW_LEN samples, and the output is the window sum divided by
// WINDOW_LEN, truncated toward zero. Exactly one output beat per input beat,
// in order. The windows start as zeros after reset, so the first WINDOW_LEN
// outputs average those zeros in. From input accept to output valid a sample
// moves through the corrected-sample register and then the result register.
// Throughput is one beat per cycle unless the output stalls; a running sum per
// axis replaces the window walk, so nothing in the datapath iterates. The
// result register doubles as the stall buffer: while a result waits, one
// more sample is taken into the first stage, and only then does in ready
// drop. Bias registers (index 0..5: accel x/y/z, gyro x/y/z) are written
// through cfg_we/cfg_idx/cfg_wdata and should only be changed while the
// pipeline is empty; writes to indexes 6 and 7 are ignored.
module imu_offset_moving_average_top
  import imo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  imo_in_if.sink    in_s,
  imo_out_if.source out_s,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_idx,
  input  sample_t   cfg_wdata
);

  axes_t      raw;
  axes_t      corr;
  axes_t      avg;
  logic       in_beat;
  logic       adv;

  // stage 1: bias-corrected sample
  logic       s1_valid_r;
  axes_t      s1_corr_r;
  // stage 2: result register
  logic       out_valid_r;
  axes_t      out_data_r;
  // shared ring slot
  pos_t       pos_r;
  pos_t       pos_nxt;
  lane_ctrl_t lane_ctrl;

  assign raw[AX_ACCEL_X] = in_s.accel_in_x;
  assign raw[AX_ACCEL_Y] = in_s.accel_in_y;
  assign raw[AX_ACCEL_Z] = in_s.accel_in_z;
  assign raw[AX_GYRO_X]  = in_s.gyro_in_x;
  assign raw[AX_GYRO_Y]  = in_s.gyro_in_y;
  assign raw[AX_GYRO_Z]  = in_s.gyro_in_z;

  // result register free or draining this cycle
  assign adv        = !out_valid_r || out_s.ready;
  assign in_s.ready = !s1_valid_r || adv;
  assign in_beat    = in_s.valid && in_s.ready;

  imo_bias u_bias (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .raw       (raw),
    .corr      (corr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_corr_r <= corr;
    end
  end

  // window update happens as the sample moves into the result register
  assign lane_ctrl.upd = s1_valid_r && adv;
  assign lane_ctrl.pos = pos_r;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    imo_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .corr  (s1_corr_r[a]),
      .avg   (avg[a])
    );
  end

  assign pos_nxt = (pos_r == pos_t'(WINDOW_LEN - 1)) ? '0 : pos_r + pos_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctrl.upd) begin
      out_data_r <= avg;
    end
  end

  assign out_s.valid       = out_valid_r;
  assign out_s.accel_out_x = out_data_r[AX_ACCEL_X];
  assign out_s.accel_out_y = out_data_r[AX_ACCEL_Y];
  assign out_s.accel_out_z = out_data_r[AX_ACCEL_Z];
  assign out_s.gyro_out_x  = out_data_r[AX_GYRO_X];
  assign out_s.gyro_out_y  = out_data_r[AX_GYRO_Y];
  assign out_s.gyro_out_z  = out_data_r[AX_GYRO_Z];

endmodule

// File: sv/imo_bias.sv
// Bias register file and per-axis offset subtraction (16-bit wraparound).
// Depends on imo_pkg.
module imo_bias
  import imo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_idx,
  input  sample_t  cfg_wdata,
  input  axes_t    raw,
  output axes_t    corr
);

  axes_t bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ACCEL_BIAS_X,
        REG_ACCEL_BIAS_Y,
        REG_ACCEL_BIAS_Z,
        REG_GYRO_BIAS_X,
        REG_GYRO_BIAS_Y,
        REG_GYRO_BIAS_Z: begin
          bias_r[cfg_idx] <= cfg_wdata;
        end
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      corr[a] = raw[a] - bias_r[a];
    end
  end

endmodule

// File: sv/imo_lane.sv
// One axis of the filter: ring of the last WINDOW_LEN samples, running sum
// and truncating divide. Depends on imo_pkg.
module imo_lane
  import imo_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  sample_t    corr,
  output sample_t    avg
);

  sample_t ring_r [WINDOW_LEN];
  wsum_t   sum_r;
  wsum_t   sum_nxt;
  wsum_t   sum_adj;
  wsum_t   quot;

  always_comb begin
    sum_nxt = sum_r + SUM_W'(corr) - SUM_W'(ring_r[ctrl.pos]);
    // round toward zero: bias negative sums up before the arithmetic shift
    sum_adj = sum_nxt[SUM_W-1] ? (sum_nxt + wsum_t'(WINDOW_LEN - 1)) : sum_nxt;
    quot    = sum_adj >>> POS_W;
    avg     = quot[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= '0;
      end
    end else if (ctrl.upd) begin
      sum_r            <= sum_nxt;
      ring_r[ctrl.pos] <= corr;
    end
  end

endmodule

// File: sv/imo_checker.sv
// Port-level checks for the IMU filter top level, bound in below.
// Depends on imo_pkg and imu_offset_moving_average_top.
module imo_checker
  import imo_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input axes_t out_data
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // a new result appears only after its sample beat has passed through stage one
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_beat, 2))
    else $error("result without matching input beat");

  // with the result stalled and stage one filled, input must back off
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && out_valid && !out_ready) ##1 !out_ready |-> !in_ready)
    else $error("input accepted with pipeline full");

  // stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind imu_offset_moving_average_top imo_checker u_imo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  ({out_s.gyro_out_z, out_s.gyro_out_y, out_s.gyro_out_x,
               out_s.accel_out_z, out_s.accel_out_y, out_s.accel_out_x})
);

// File: bench/testbench.sv
// Self-checking bench for imu_offset_moving_average_top: streams six-axis samples
// under random idling and backpressure and checks every filtered beat in order.
// Depends on imo_pkg, imo_if and the filter RTL.
module testbench;
  import imo_pkg::*;

  // Indexes past the last bias register; writes there must leave the block alone.
  localparam cfg_idx_t IDX_SPARE_6 = 3'd6;
  localparam cfg_idx_t IDX_SPARE_7 = 3'd7;
  localparam cfg_reg_t BIAS_REG [NUM_AXES] = '{REG_ACCEL_BIAS_X, REG_ACCEL_BIAS_Y,
                                                REG_ACCEL_BIAS_Z, REG_GYRO_BIAS_X,
                                                REG_GYRO_BIAS_Y, REG_GYRO_BIAS_Z};
  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;
  localparam int LOG_CAP = 50;

  typedef enum int {VAL_FULL, VAL_SMALL, VAL_EDGE} val_mode_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  sample_t  cfg_wdata;

  imo_in_if  in_ch ();
  imo_out_if out_ch ();

  imu_offset_moving_average_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 4-unit period clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Filter model: bias copy, per-axis window rings, running sums, shared slot.
  // ---------------------------------------------------------------------------
  sample_t bias_copy [NUM_AXES];
  sample_t ring_mem [NUM_AXES][WINDOW_LEN];
  int      ring_sum [NUM_AXES];
  int      ring_slot;
  axes_t   pending_avgs [$];

  string axis_name [NUM_AXES] = '{"accel_x", "accel_y", "accel_z",
                                  "gyro_x", "gyro_y", "gyro_z"};

  int error_count;
  int sent_beats;
  int checked_beats;
  int cfg_writes;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  // Subtract bias with 16-bit wrap, swap the oldest ring entry, divide the
  // running sum; SV int division truncates toward zero like the spec wants.
  function automatic axes_t average_sample(axes_t raw);
    axes_t   avg;
    sample_t corr;
    for (int a = 0; a < NUM_AXES; a++) begin
      corr = raw[a] - bias_copy[a];
      ring_sum[a] += int'(corr) - int'(ring_mem[a][ring_slot]);
      ring_mem[a][ring_slot] = corr;
      avg[a] = sample_t'(ring_sum[a] / WINDOW_LEN);
    end
    ring_slot = (ring_slot + 1) % WINDOW_LEN;
    return avg;
  endfunction

  function automatic axes_t make_axes(sample_t ax, sample_t ay, sample_t az,
                                      sample_t gx, sample_t gy, sample_t gz);
    axes_t r;
    r[AX_ACCEL_X] = ax;
    r[AX_ACCEL_Y] = ay;
    r[AX_ACCEL_Z] = az;
    r[AX_GYRO_X]  = gx;
    r[AX_GYRO_Y]  = gy;
    r[AX_GYRO_Z]  = gz;
    return r;
  endfunction

  function automatic sample_t rand_axis(val_mode_t m);
    case (m)
      VAL_SMALL: return sample_t'($urandom_range(48) - 24);
      VAL_EDGE: begin
        case ($urandom_range(4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return sample_t'(0);
          3:       return sample_t'(-1);
          default: return sample_t'(1);
        endcase
      end
      default:   return sample_t'($urandom);
    endcase
  endfunction

  // Half full-range values; small ones hit truncation of negative sums,
  // edge ones hit the wraparound of the bias subtraction.
  function automatic axes_t rand_axes();
    axes_t r;
    int    pick;
    for (int a = 0; a < NUM_AXES; a++) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        r[a] = rand_axis(VAL_FULL);
      end else if (pick < 8) begin
        r[a] = rand_axis(VAL_SMALL);
      end else begin
        r[a] = rand_axis(VAL_EDGE);
      end
    end
    return r;
  endfunction

  function automatic axes_t rand_biases();
    axes_t r;
    for (int a = 0; a < NUM_AXES; a++) begin
      r[a] = ($urandom_range(3) == 0) ? rand_axis(VAL_EDGE) : rand_axis(VAL_FULL);
    end
    return r;
  endfunction

  // Only the first LOG_CAP mismatches are printed, all are counted.
  task automatic report_mismatch(string msg);
    if (error_count < LOG_CAP) begin
      $display("MISMATCH: %s", msg);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sampled at the rising edge. Result beats are checked against the
  // oldest pending average; accepted sample beats feed the model.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    axes_t got;
    axes_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = make_axes(out_ch.accel_out_x, out_ch.accel_out_y, out_ch.accel_out_z,
                        out_ch.gyro_out_x, out_ch.gyro_out_y, out_ch.gyro_out_z);
        if (pending_avgs.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no sample pending",
                                    checked_beats));
        end else begin
          want = pending_avgs.pop_front();
          for (int a = 0; a < NUM_AXES; a++) begin
            if (got[a] !== want[a]) begin
              report_mismatch($sformatf("beat %0d %s: expected %0d got %0d",
                                        checked_beats, axis_name[a], want[a], got[a]));
            end
          end
        end
        checked_beats++;
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_avgs.push_back(average_sample(
          make_axes(in_ch.accel_in_x, in_ch.accel_in_y, in_ch.accel_in_z,
                    in_ch.gyro_in_x, in_ch.gyro_in_y, in_ch.gyro_in_z)));
        sent_beats++;
      end
    end
  end

  // Receiver: random ready at the falling edge, or a counted hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One sample beat: random gap first, then hold valid until accepted. Valid
  // is left high on return so back-to-back beats never drop it.
  task automatic send_sample(axes_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.accel_in_x <= s[AX_ACCEL_X];
    in_ch.accel_in_y <= s[AX_ACCEL_Y];
    in_ch.accel_in_z <= s[AX_ACCEL_Z];
    in_ch.gyro_in_x  <= s[AX_GYRO_X];
    in_ch.gyro_in_y  <= s[AX_GYRO_Y];
    in_ch.gyro_in_z  <= s[AX_GYRO_Z];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every predicted average has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(cfg_idx_t idx, sample_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < NUM_AXES) begin
      bias_copy[idx] = val;
    end
    cfg_writes++;
  endtask

  // Bias writes only with the pipeline empty; every item yields a result,
  // so an empty queue means the block is idle.
  task automatic program_biases(axes_t b, bit with_spares);
    wait_drained();
    for (int a = 0; a < NUM_AXES; a++) begin
      write_reg(BIAS_REG[a], b[a]);
    end
    if (with_spares) begin
      write_reg(IDX_SPARE_6, S_MAX);
      write_reg(IDX_SPARE_7, S_MIN);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zeroed windows after reset: the first eight averages ramp up from zero.
  task automatic test_startup_ramp();
    for (int i = 0; i < WINDOW_LEN; i++) begin
      send_sample(make_axes(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN));
    end
    for (int i = 0; i < 4; i++) begin
      send_sample(make_axes(S_MIN, 16'sd0, -16'sd1, S_MAX, 16'sd1, S_MIN));
    end
  endtask

  // Extreme biases so the subtraction wraps both ways; spare indexes written
  // with nonzero data must not disturb any axis.
  task automatic test_bias_wraparound();
    program_biases(make_axes(S_MIN, S_MAX, -16'sd1, 16'sd1, S_MAX, S_MIN), 1'b1);
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0:       send_sample(make_axes(S_MAX, S_MIN, S_MIN, S_MAX, 16'sd0, 16'sd0));
        1:       send_sample(make_axes(S_MIN, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX));
        default: send_sample(make_axes(16'sd0, 16'sd0, S_MAX, S_MIN, S_MAX, S_MIN));
      endcase
    end
  endtask

  task automatic test_random_stream();
    program_biases(rand_biases(), 1'b0);
    for (int i = 0; i < 140; i++) begin
      send_sample(rand_axes());
    end
  endtask

  // Long stretch with no idling on either side: one beat per cycle.
  task automatic test_full_rate();
    program_biases(make_axes(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX), 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 80; i++) begin
      send_sample(rand_axes());
    end
    tx_idle_pct = 30;
    rx_idle_pct = 30;
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe fills and
  // in ready drops; then the sender pauses until every result is out.
  task automatic test_output_backpressure();
    program_biases(rand_biases(), 1'b0);
    rx_hold_cycles = 60;
    for (int i = 0; i < 30; i++) begin
      send_sample(rand_axes());
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_sample(rand_axes());
    end
  endtask

  // Several bias settings in turn, ending back at zero.
  task automatic test_bias_sweep();
    axes_t b;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       b = make_axes(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
        1:       b = make_axes(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN);
        2:       b = rand_biases();
        default: b = '0;
      endcase
      program_biases(b, 1'b0);
      for (int i = 0; i < 25; i++) begin
        send_sample(rand_axes());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_ACCEL_BIAS_X;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.accel_in_x = '0;
    in_ch.accel_in_y = '0;
    in_ch.accel_in_z = '0;
    in_ch.gyro_in_x  = '0;
    in_ch.gyro_in_y  = '0;
    in_ch.gyro_in_z  = '0;
    error_count      = 0;
    sent_beats       = 0;
    checked_beats    = 0;
    cfg_writes       = 0;
    tx_idle_pct      = 30;
    rx_idle_pct      = 30;
    rx_hold_cycles   = 0;
    ring_slot        = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      bias_copy[a] = '0;
      ring_sum[a]  = 0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        ring_mem[a][k] = '0;
      end
    end

    // Synchronous reset, released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_startup_ramp();
    test_bias_wraparound();
    test_random_stream();
    test_full_rate();
    test_output_backpressure();
    test_bias_sweep();

    // Drain, then keep watching for stray beats.
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_avgs.size() != 0) begin
      report_mismatch($sformatf("%0d averages never came out", pending_avgs.size()));
    end

    $display("Streamed %0d samples and checked %0d filtered beats across %0d bias writes,",
             sent_beats, checked_beats, cfg_writes);
    $display("with start-up ramp, bias wraparound, full-rate and backpressure phases.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: ~400 beats finish long before this timeout, even with idling and the hold-off.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: imu_offset_moving_average_top.f
sv/imo_pkg.sv
sv/imo_if.sv
sv/imo_bias.sv
sv/imo_lane.sv
sv/imu_offset_moving_average_top.sv
sv/imo_checker.sv
bench/testbench.sv
